// ----- rtl/siu_pkg.sv -----
// ----------------------------------------------------------------------------
// siu_pkg
// Shared types for the segment intersection unit.
// ----------------------------------------------------------------------------
package siu_pkg;

    typedef enum logic {
        OP_SEG  = 1'b0,
        OP_RECT = 1'b1
    } op_t;

    localparam int LANES = 4;

endpackage

// ----- rtl/siu_if.sv -----
// ----------------------------------------------------------------------------
// siu_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface siu_in_if #(
    parameter int COORD_BITS = 16
) ();
    import siu_pkg::*;

    logic                         valid;
    logic                         ready;
    op_t                          opcode;
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] other_a;
    logic signed [COORD_BITS-1:0] other_b;
    logic signed [COORD_BITS-1:0] other_c;
    logic signed [COORD_BITS-1:0] other_d;

    modport source (
        output valid, opcode, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               other_a, other_b, other_c, other_d,
        input  ready
    );
    modport sink (
        input  valid, opcode, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               other_a, other_b, other_c, other_d,
        output ready
    );
endinterface

interface siu_out_if #(
    parameter int OUT_BITS = 24
) ();
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ----- rtl/siu_test.sv -----
// ----------------------------------------------------------------------------
// siu_test
// Four-stage exact parametric test: differences, products, sums, decide.
// ----------------------------------------------------------------------------
module siu_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  siu_pkg::op_t                   opcode,
    input  logic signed [COORD_BITS-1:0]   p1x,
    input  logic signed [COORD_BITS-1:0]   p1y,
    input  logic signed [COORD_BITS-1:0]   p2x,
    input  logic signed [COORD_BITS-1:0]   p2y,
    input  logic signed [COORD_BITS-1:0]   oa,
    input  logic signed [COORD_BITS-1:0]   ob,
    input  logic signed [COORD_BITS-1:0]   oc,
    input  logic signed [COORD_BITS-1:0]   od,
    output logic                           out_valid,
    output siu_pkg::op_t                   out_op,
    output logic                           out_hit,
    output logic signed [2*COORD_BITS+3:0] out_na,
    output logic signed [2*COORD_BITS+3:0] out_den,
    output logic signed [COORD_BITS-1:0]   out_p1x,
    output logic signed [COORD_BITS-1:0]   out_p1y,
    output logic signed [COORD_BITS:0]     out_d1x,
    output logic signed [COORD_BITS:0]     out_d1y
);
    import siu_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int WW = C + 2;
    localparam int MW = DW + WW;
    localparam int PW = 2 * C + 4;

    // stage 1: differences for the four lanes
    logic signed [DW-1:0] rx, by;
    logic signed [DW-1:0] q1x [LANES];
    logic signed [DW-1:0] q1y [LANES];
    logic signed [DW-1:0] d2x_next [LANES];
    logic signed [DW-1:0] d2y_next [LANES];
    logic signed [WW-1:0] wx_next [LANES];
    logic signed [WW-1:0] wy_next [LANES];
    logic signed [DW-1:0] d1x_next, d1y_next;

    always_comb
    begin
        rx = DW'(oa) + DW'(oc);
        by = DW'(ob) + DW'(od);
        d1x_next = DW'(p2x) - DW'(p1x);
        d1y_next = DW'(p2y) - DW'(p1y);
        q1x[0] = DW'(oa);
        q1y[0] = DW'(ob);
        if (opcode == OP_SEG)
        begin
            d2x_next[0] = DW'(oc) - DW'(oa);
            d2y_next[0] = DW'(od) - DW'(ob);
        end
        else
        begin
            d2x_next[0] = DW'(oc);
            d2y_next[0] = '0;
        end
        q1x[1] = DW'(oa);
        q1y[1] = DW'(ob);
        d2x_next[1] = '0;
        d2y_next[1] = DW'(od);
        q1x[2] = rx;
        q1y[2] = DW'(ob);
        d2x_next[2] = '0;
        d2y_next[2] = DW'(od);
        q1x[3] = DW'(oa);
        q1y[3] = by;
        d2x_next[3] = DW'(oc);
        d2y_next[3] = '0;
        for (int l = 0; l < LANES; l++)
        begin
            wx_next[l] = WW'(p1x) - WW'(q1x[l]);
            wy_next[l] = WW'(p1y) - WW'(q1y[l]);
        end
    end

    logic                 s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    op_t                  s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    logic signed [C-1:0]  s1_p1x_reg, s1_p1y_reg, s2_p1x_reg, s2_p1y_reg;
    logic signed [C-1:0]  s3_p1x_reg, s3_p1y_reg, s4_p1x_reg, s4_p1y_reg;
    logic signed [DW-1:0] s1_d1x_reg, s1_d1y_reg, s2_d1x_reg, s2_d1y_reg;
    logic signed [DW-1:0] s3_d1x_reg, s3_d1y_reg, s4_d1x_reg, s4_d1y_reg;
    logic signed [DW-1:0] s1_d2x_reg [LANES];
    logic signed [DW-1:0] s1_d2y_reg [LANES];
    logic signed [WW-1:0] s1_wx_reg [LANES];
    logic signed [WW-1:0] s1_wy_reg [LANES];
    logic signed [MW-1:0] s2_pa_reg [LANES];
    logic signed [MW-1:0] s2_pb_reg [LANES];
    logic signed [MW-1:0] s2_pc_reg [LANES];
    logic signed [MW-1:0] s2_pd_reg [LANES];
    logic signed [MW-1:0] s2_pe_reg [LANES];
    logic signed [MW-1:0] s2_pf_reg [LANES];
    logic signed [PW-1:0] s3_den_reg [LANES];
    logic signed [PW-1:0] s3_na_reg [LANES];
    logic signed [PW-1:0] s3_nb_reg [LANES];
    logic                 s4_hit_reg;
    logic signed [PW-1:0] s4_na_reg, s4_den_reg;

    // stage 4 decide
    logic signed [PW-1:0] den_n [LANES];
    logic signed [PW-1:0] na_n [LANES];
    logic signed [PW-1:0] nb_n [LANES];
    logic [LANES-1:0]     lane_hit;
    logic                 hit_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (s3_den_reg[l][PW-1])
            begin
                den_n[l] = -s3_den_reg[l];
                na_n[l]  = -s3_na_reg[l];
                nb_n[l]  = -s3_nb_reg[l];
            end
            else
            begin
                den_n[l] = s3_den_reg[l];
                na_n[l]  = s3_na_reg[l];
                nb_n[l]  = s3_nb_reg[l];
            end
            lane_hit[l] = (s3_den_reg[l] != '0) && !na_n[l][PW-1] && (na_n[l] <= den_n[l])
                       && !nb_n[l][PW-1] && (nb_n[l] <= den_n[l]);
        end
        hit_next = lane_hit[0] || ((s3_op_reg == OP_RECT) && (|lane_hit[LANES-1:1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg  <= opcode;
            s1_p1x_reg <= p1x;
            s1_p1y_reg <= p1y;
            s1_d1x_reg <= d1x_next;
            s1_d1y_reg <= d1y_next;
            s2_op_reg  <= s1_op_reg;
            s2_p1x_reg <= s1_p1x_reg;
            s2_p1y_reg <= s1_p1y_reg;
            s2_d1x_reg <= s1_d1x_reg;
            s2_d1y_reg <= s1_d1y_reg;
            s3_op_reg  <= s2_op_reg;
            s3_p1x_reg <= s2_p1x_reg;
            s3_p1y_reg <= s2_p1y_reg;
            s3_d1x_reg <= s2_d1x_reg;
            s3_d1y_reg <= s2_d1y_reg;
            s4_op_reg  <= s3_op_reg;
            s4_p1x_reg <= s3_p1x_reg;
            s4_p1y_reg <= s3_p1y_reg;
            s4_d1x_reg <= s3_d1x_reg;
            s4_d1y_reg <= s3_d1y_reg;
            s4_hit_reg <= hit_next;
            s4_na_reg  <= na_n[0];
            s4_den_reg <= den_n[0];
            for (int l = 0; l < LANES; l++)
            begin
                s1_d2x_reg[l] <= d2x_next[l];
                s1_d2y_reg[l] <= d2y_next[l];
                s1_wx_reg[l]  <= wx_next[l];
                s1_wy_reg[l]  <= wy_next[l];
                s2_pa_reg[l]  <= MW'(s1_d2y_reg[l]) * MW'(s1_d1x_reg);
                s2_pb_reg[l]  <= MW'(s1_d2x_reg[l]) * MW'(s1_d1y_reg);
                s2_pc_reg[l]  <= MW'(s1_d2x_reg[l]) * MW'(s1_wy_reg[l]);
                s2_pd_reg[l]  <= MW'(s1_d2y_reg[l]) * MW'(s1_wx_reg[l]);
                s2_pe_reg[l]  <= MW'(s1_d1x_reg) * MW'(s1_wy_reg[l]);
                s2_pf_reg[l]  <= MW'(s1_d1y_reg) * MW'(s1_wx_reg[l]);
                s3_den_reg[l] <= PW'(s2_pa_reg[l]) - PW'(s2_pb_reg[l]);
                s3_na_reg[l]  <= PW'(s2_pc_reg[l]) - PW'(s2_pd_reg[l]);
                s3_nb_reg[l]  <= PW'(s2_pe_reg[l]) - PW'(s2_pf_reg[l]);
            end
        end
    end

    assign out_valid = s4_v_reg;
    assign out_op    = s4_op_reg;
    assign out_hit   = s4_hit_reg;
    assign out_na    = s4_na_reg;
    assign out_den   = s4_den_reg;
    assign out_p1x   = s4_p1x_reg;
    assign out_p1y   = s4_p1y_reg;
    assign out_d1x   = s4_d1x_reg;
    assign out_d1y   = s4_d1y_reg;

endmodule

// ----- rtl/siu_div.sv -----
// ----------------------------------------------------------------------------
// siu_div
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// ----------------------------------------------------------------------------
module siu_div #(
    parameter int PW    = 36,
    parameter int QW    = 24,
    parameter int TAG_W = 19
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [PW+QW-1:0]   num,
    input  logic [PW-1:0]      den,
    input  logic [TAG_W-1:0]   tag,
    output logic               out_valid,
    output logic [QW:0]        q,
    output logic [TAG_W-1:0]   out_tag
);
    logic [PW-1:0]    r_reg   [QW];
    logic [QW-1:0]    low_reg [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [PW-1:0]    den_reg [QW];
    logic [TAG_W-1:0] tag_reg [QW];
    logic             v_reg   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_step
            logic [PW-1:0]    r_src, den_src;
            logic [QW-1:0]    low_src, q_src;
            logic [TAG_W-1:0] tag_src;
            logic             v_src;
            logic [PW:0]      t;
            logic             ge;
            logic [PW-1:0]    r_next;

            if (k == 0)
            begin : g_first
                assign r_src   = num[PW+QW-1:QW];
                assign low_src = num[QW-1:0];
                assign q_src   = '0;
                assign den_src = den;
                assign tag_src = tag;
                assign v_src   = in_valid;
            end
            else
            begin : g_rest
                assign r_src   = r_reg[k-1];
                assign low_src = low_reg[k-1];
                assign q_src   = q_reg[k-1];
                assign den_src = den_reg[k-1];
                assign tag_src = tag_reg[k-1];
                assign v_src   = v_reg[k-1];
            end

            always_comb
            begin
                t  = {r_src, low_src[QW-1]};
                ge = (t >= {1'b0, den_src});
                r_next = ge ? PW'(t - {1'b0, den_src}) : t[PW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]   <= r_next;
                    low_reg[k] <= low_src << 1;
                    q_reg[k]   <= {q_src[QW-2:0], ge};
                    den_reg[k] <= den_src;
                    tag_reg[k] <= tag_src;
                end
            end
        end
    endgenerate

    // rounding stage: half or more of the divisor rounds up
    logic             rd_v_reg;
    logic [QW:0]      rd_q_reg;
    logic [TAG_W-1:0] rd_tag_reg;
    logic             up;

    assign up = ({r_reg[QW-1], 1'b0} >= {1'b0, den_reg[QW-1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_v_reg <= v_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_q_reg   <= (QW+1)'(q_reg[QW-1]) + (QW+1)'(up);
            rd_tag_reg <= tag_reg[QW-1];
        end
    end

    assign out_valid = rd_v_reg;
    assign q         = rd_q_reg;
    assign out_tag   = rd_tag_reg;

endmodule

// ----- rtl/segment_intersection_unit_core.sv -----
// A request passes the test stages, the scale stage, the divider and its rounding stage, then the output stage.
// Throughput: one word per cycle; the whole pipeline holds while the response stalls.
// Depth is set by the divider, one quotient bit per stage, for the crossing point.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_unit_core
// Segment/segment and segment/rectangle-edge test; Q-format point for segment hits.
// ----------------------------------------------------------------------------
module segment_intersection_unit_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    siu_in_if.sink   req,
    siu_out_if.source rsp
);
    import siu_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * C + 4;
    localparam int QW    = C + F;
    localparam int OW    = C + F;
    localparam int NW    = PW + C;
    localparam int TAG_W = C + 3;

    logic en;
    logic out_v_reg;

    assign en        = !out_v_reg || rsp.ready;
    assign req.ready = en;

    logic                  t_valid, t_hit;
    op_t                   t_op;
    logic signed [PW-1:0]  t_na, t_den;
    logic signed [C-1:0]   t_p1x, t_p1y;
    logic signed [C:0]     t_d1x, t_d1y;

    siu_test #(.COORD_BITS(C)) u_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (req.valid),
        .opcode   (req.opcode),
        .p1x      (req.seg_start_x),
        .p1y      (req.seg_start_y),
        .p2x      (req.seg_end_x),
        .p2y      (req.seg_end_y),
        .oa       (req.other_a),
        .ob       (req.other_b),
        .oc       (req.other_c),
        .od       (req.other_d),
        .out_valid(t_valid),
        .out_op   (t_op),
        .out_hit  (t_hit),
        .out_na   (t_na),
        .out_den  (t_den),
        .out_p1x  (t_p1x),
        .out_p1y  (t_p1y),
        .out_d1x  (t_d1x),
        .out_d1y  (t_d1y)
    );

    // scale stage: numA * |d1|
    logic [C-1:0]     magx, magy;
    logic             sc_v_reg;
    logic [NW-1:0]    sc_nx_reg, sc_ny_reg;
    logic [PW-1:0]    sc_den_reg;
    logic [TAG_W-1:0] sc_tagx_reg, sc_tagy_reg;
    logic             keep;

    always_comb
    begin
        magx = t_d1x[C] ? C'(-t_d1x) : t_d1x[C-1:0];
        magy = t_d1y[C] ? C'(-t_d1y) : t_d1y[C-1:0];
        keep = t_hit && (t_op == OP_SEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_v_reg <= t_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_nx_reg   <= NW'(unsigned'(t_na)) * NW'(magx);
            sc_ny_reg   <= NW'(unsigned'(t_na)) * NW'(magy);
            sc_den_reg  <= t_den;
            sc_tagx_reg <= {t_hit, keep, t_d1x[C], t_p1x};
            sc_tagy_reg <= {t_hit, keep, t_d1y[C], t_p1y};
        end
    end

    logic             dx_v, dy_v;
    logic [QW:0]      qx, qy;
    logic [TAG_W-1:0] tagx, tagy;

    siu_div #(.PW(PW), .QW(QW), .TAG_W(TAG_W)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sc_v_reg),
        .num      ((PW+QW)'(sc_nx_reg) << F),
        .den      (sc_den_reg),
        .tag      (sc_tagx_reg),
        .out_valid(dx_v),
        .q        (qx),
        .out_tag  (tagx)
    );

    siu_div #(.PW(PW), .QW(QW), .TAG_W(TAG_W)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sc_v_reg),
        .num      ((PW+QW)'(sc_ny_reg) << F),
        .den      (sc_den_reg),
        .tag      (sc_tagy_reg),
        .out_valid(dy_v),
        .q        (qy),
        .out_tag  (tagy)
    );

    // output stage: base * 2^F plus or minus offset, or zero without a segment hit
    logic [OW-1:0] bx, by, cx_next, cy_next;
    logic          out_hit_reg;
    logic [OW-1:0] out_cx_reg, out_cy_reg;

    always_comb
    begin
        bx = OW'(unsigned'(tagx[C-1:0])) << F;
        by = OW'(unsigned'(tagy[C-1:0])) << F;
        cx_next = tagx[C] ? bx - OW'(qx) : bx + OW'(qx);
        cy_next = tagy[C] ? by - OW'(qy) : by + OW'(qy);
        if (!tagx[C+1])
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dx_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= tagx[C+2];
            out_cx_reg  <= cx_next;
            out_cy_reg  <= cy_next;
        end
    end

    assign rsp.valid   = out_v_reg;
    assign rsp.hit     = out_hit_reg;
    assign rsp.cross_x = out_cx_reg;
    assign rsp.cross_y = out_cy_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dx_v == dy_v) else $error("divider lanes out of step");

    a_keep_den: assert property (@(posedge clk) disable iff (!rst_n)
        sc_v_reg && sc_tagx_reg[C+1] |-> sc_den_reg != '0)
        else $error("point requested with zero denominator");

    a_keep_hit: assert property (@(posedge clk) disable iff (!rst_n)
        sc_v_reg && sc_tagx_reg[C+1] |-> sc_tagx_reg[C+2])
        else $error("point requested without a hit");

    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hit |-> rsp.cross_x == '0 && rsp.cross_y == '0)
        else $error("nonzero point without a hit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sc_v_reg) && $stable(dx_v))
        else $error("pipeline moved during a stall");

endmodule

// ----- test/siu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siu_checker
// Watches the request and response channels, predicts the hit flag and the
// crossing point of every accepted request word, and compares the response
// words against the predictions in order.
// ----------------------------------------------------------------------------
module siu_checker (
    input  logic clk,
    input  logic rst_n,
    siu_in_if    req,
    siu_out_if   rsp,
    output int   errors,
    output int   pending,
    output int   hits_seen,
    output int   words_seen
);
    import siu_pkg::*;

    localparam int FRAC = 8;
    localparam int OW   = 24;

    typedef struct {
        logic                 hit;
        logic signed [OW-1:0] cross_x;
        logic signed [OW-1:0] cross_y;
    } crossing_t;

    crossing_t crossing_q[$];

    // Exact parametric test on integers; normalized so den > 0 on a hit.
    function automatic bit pair_crosses(longint p1x, longint p1y, longint p2x, longint p2y,
                                        longint q1x, longint q1y, longint q2x, longint q2y,
                                        output longint na, output longint den);
        longint d1x, d1y, d2x, d2y, wx, wy, nb;
        d1x = p2x - p1x;
        d1y = p2y - p1y;
        d2x = q2x - q1x;
        d2y = q2y - q1y;
        wx  = p1x - q1x;
        wy  = p1y - q1y;
        den = d2y * d1x - d2x * d1y;
        na  = d2x * wy - d2y * wx;
        nb  = d1x * wy - d1y * wx;
        if (den == 0)
            return 0;
        if (den < 0)
        begin
            den = -den;
            na  = -na;
            nb  = -nb;
        end
        return !(na < 0 || na > den || nb < 0 || nb > den);
    endfunction

    // Offset rounded to nearest, ties away from zero, added to exact base.
    function automatic logic [OW-1:0] fixed_coord(longint base, longint delta,
                                                  longint na, longint den);
        longint unsigned mag, m, q, r;
        longint          res;
        mag = (delta < 0) ? -delta : delta;
        m   = (na * mag) << FRAC;
        q   = m / den;
        r   = m % den;
        if ((r << 1) >= den)
            q++;
        res = (delta < 0) ? (base << FRAC) - longint'(q) : (base << FRAC) + longint'(q);
        return res[OW-1:0];
    endfunction

    function automatic crossing_t predict_crossing(op_t op,
                                                   longint p1x, longint p1y,
                                                   longint p2x, longint p2y,
                                                   longint a, longint b,
                                                   longint c, longint d);
        crossing_t res;
        longint    na, den, rx, by;
        res.hit     = 0;
        res.cross_x = '0;
        res.cross_y = '0;
        if (op == OP_SEG)
        begin
            if (pair_crosses(p1x, p1y, p2x, p2y, a, b, c, d, na, den))
            begin
                res.hit     = 1;
                res.cross_x = fixed_coord(p1x, p2x - p1x, na, den);
                res.cross_y = fixed_coord(p1y, p2y - p1y, na, den);
            end
        end
        else
        begin
            rx = a + c;
            by = b + d;
            res.hit = pair_crosses(p1x, p1y, p2x, p2y, a, b, rx, b, na, den)
                   || pair_crosses(p1x, p1y, p2x, p2y, a, b, a, by, na, den)
                   || pair_crosses(p1x, p1y, p2x, p2y, rx, b, rx, by, na, den)
                   || pair_crosses(p1x, p1y, p2x, p2y, a, by, rx, by, na, den);
        end
        return res;
    endfunction

    initial
    begin
        errors     = 0;
        pending    = 0;
        hits_seen  = 0;
        words_seen = 0;
    end

    always @(posedge clk)
    begin
        crossing_t exp_w;
        if (rst_n && req.valid && req.ready)
            crossing_q.push_back(predict_crossing(req.opcode,
                longint'(req.seg_start_x), longint'(req.seg_start_y),
                longint'(req.seg_end_x), longint'(req.seg_end_y),
                longint'(req.other_a), longint'(req.other_b),
                longint'(req.other_c), longint'(req.other_d)));
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_seen++;
            if (crossing_q.size() == 0)
            begin
                $error("response word with no request outstanding");
                errors++;
            end
            else
            begin
                exp_w = crossing_q.pop_front();
                if (exp_w.hit)
                    hits_seen++;
                if (rsp.hit !== exp_w.hit)
                begin
                    $error("hit: expected %0d actual %0d", exp_w.hit, rsp.hit);
                    errors++;
                end
                if (rsp.cross_x !== exp_w.cross_x)
                begin
                    $error("cross_x: expected %0d actual %0d", exp_w.cross_x, rsp.cross_x);
                    errors++;
                end
                if (rsp.cross_y !== exp_w.cross_y)
                begin
                    $error("cross_y: expected %0d actual %0d", exp_w.cross_y, rsp.cross_y);
                    errors++;
                end
            end
        end
        pending = crossing_q.size();
    end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random segment/segment and segment/rectangle words into
// the intersection unit with random gaps and back-pressure; the checker
// compares every response word.
// ----------------------------------------------------------------------------
module tb_top;
    import siu_pkg::*;

    localparam int N_RANDOM = 1880;

    logic clk;
    logic rst_n;
    logic stall_rsp;
    int   errors, pending, hits_seen, words_seen;
    int   sent;

    siu_in_if  #(.COORD_BITS(16)) req ();
    siu_out_if #(.OUT_BITS(24))   rsp ();

    segment_intersection_unit_core #(.COORD_BITS(16), .FRAC_BITS(8)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    siu_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .errors     (errors),
        .pending    (pending),
        .hits_seen  (hits_seen),
        .words_seen (words_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5000000;
        $display("segment_intersection_unit_core test failed");
        $finish;
    end

    function automatic logic [15:0] rnd_coord(int span);
        if (span >= 32768)
            return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic send_word(op_t op, logic [15:0] p1x, logic [15:0] p1y,
                             logic [15:0] p2x, logic [15:0] p2y,
                             logic [15:0] a, logic [15:0] b,
                             logic [15:0] c, logic [15:0] d, int gap);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.opcode      <= op;
        req.seg_start_x <= p1x;
        req.seg_start_y <= p1y;
        req.seg_end_x   <= p2x;
        req.seg_end_y   <= p2y;
        req.other_a     <= a;
        req.other_b     <= b;
        req.other_c     <= c;
        req.other_d     <= d;
        req.valid       <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random(int gap);
        int   span, kind;
        op_t  op;
        logic [15:0] f[8];
        kind = $urandom_range(0, 9);
        span = (kind < 6) ? 200 : (kind < 8) ? 6000 : 32768;
        op   = op_t'($urandom_range(0, 1));
        foreach (f[i])
            f[i] = rnd_coord(span);
        if (op == OP_RECT && kind < 8 && $urandom_range(0, 3) != 0)
        begin
            // mostly ordinary positive sizes so edges get crossed
            f[6] = 16'($urandom_range(0, span));
            f[7] = 16'($urandom_range(0, span));
        end
        send_word(op, f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], gap);
    endtask

    // response side: random hold-offs plus a long forced stall
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            w = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                w = 0;
            if (w > 0 || stall_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (w) @(posedge clk);
                while (stall_rsp)
                    @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    // stall lands in a stretch of back-to-back requests so the pipe fills
    initial
    begin
        stall_rsp = 1'b0;
        wait (sent >= 420);
        @(posedge clk);
        stall_rsp <= 1'b1;
        repeat (250) @(posedge clk);
        stall_rsp <= 1'b0;
    end

    initial
    begin
        int gap;
        sent            = 0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.opcode      = OP_SEG;
        req.seg_start_x = '0;
        req.seg_start_y = '0;
        req.seg_end_x   = '0;
        req.seg_end_y   = '0;
        req.other_a     = '0;
        req.other_b     = '0;
        req.other_c     = '0;
        req.other_d     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-range diagonals crossing at the origin
        send_word(OP_SEG, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_word(OP_SEG, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                  16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0);
        // parallel, collinear overlapping, degenerate point
        send_word(OP_SEG, 0, 0, 10, 0, 0, 5, 10, 5, 0);
        send_word(OP_SEG, 0, 0, 10, 0, 5, 0, 20, 0, 1);
        send_word(OP_SEG, 3, 3, 3, 3, 0, 0, 6, 6, 0);
        // touching at an endpoint on each side, just missing
        send_word(OP_SEG, 0, 0, 10, 10, 10, 10, 20, 0, 0);
        send_word(OP_SEG, 0, 0, 10, 0, 5, 0, 5, 10, 2);
        send_word(OP_SEG, 0, 0, 10, 0, 5, 1, 5, 10, 0);
        // inexact crossing points, negative directions, rounding ties
        send_word(OP_SEG, 0, 0, 3, 1, 1, 0, 1, 5, 0);
        send_word(OP_SEG, 10, 10, -7, -3, -20, 4, 20, 0, 0);
        send_word(OP_SEG, 0, 0, 1, 0, 0, 0, 1, 1, 0);
        send_word(OP_SEG, 16'h8000, 0, 16'h7fff, 1, 0, 16'h8000, 1, 16'h7fff, 0);
        // rectangle: crossing, inside, zero size, negative size, corner touch
        send_word(OP_RECT, -50, 5, 50, 5, 0, 0, 10, 10, 0);
        send_word(OP_RECT, 2, 2, 8, 8, 0, 0, 10, 10, 0);
        send_word(OP_RECT, -5, 5, 5, 5, 0, 0, 0, 10, 0);
        send_word(OP_RECT, -5, 5, 5, 5, 0, 0, 0, 0, 0);
        send_word(OP_RECT, -15, -5, 5, -5, 0, 0, -10, -10, 3);
        send_word(OP_RECT, -5, -5, 0, 0, 0, 0, 10, 10, 0);
        send_word(OP_RECT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h8000, 16'h8000, 16'hffff, 16'hffff, 0);
        send_word(OP_RECT, 16'h8000, 0, 16'h7fff, 0,
                  16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            gap = $urandom_range(0, 10);
            if ((i / 100) % 3 == 1)
                gap = 0;
            if (i == N_RANDOM / 2)
            begin
                // let the pipeline drain completely before going on
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_random(gap);
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d request words sent, %0d response words checked, %0d hits",
                 sent, words_seen, hits_seen);
        $display("covered both opcodes, edge cases, random gaps and a long output stall");
        if (errors == 0 && pending == 0)
            $display("segment_intersection_unit_core test passed");
        else
            $display("segment_intersection_unit_core test failed");
        $finish;
    end
endmodule
